[rtl/ltbi_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the two-level basis index block.
// No dependencies; imported by every module of the block.
package ltbi_pkg;

   // Field widths of the stream payloads and configuration registers
   localparam int PATTERN_W   = 16;
   localparam int VALUE_W     = 14;
   localparam int STATUS_W    = 2;
   localparam int RANK_W      = 8;
   localparam int CFG_W       = 5;
   localparam int CSR_INDEX_W = 1;
   localparam int RSP_DATA_W  = 16;

   // Default sizing handed to the top-level parameters
   localparam int DEF_MAX_SITES        = 16;
   localparam int DEF_HALF_TABLE_DEPTH = 256;

   // Command codes carried in the request tuser
   localparam logic CMD_BUILD  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // Result status codes carried in the response tuser
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_BUILT = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SITE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONES_COUNT = 1'b1;

   // Register values after reset
   localparam logic [CFG_W-1:0] SITE_COUNT_RESET = 5'd16;
   localparam logic [CFG_W-1:0] ONES_COUNT_RESET = 5'd8;

   // Marker for a right-half entry that belongs to no basis pattern
   localparam logic [RANK_W-1:0] RANK_UNUSED = '1;

   // Table port strobes from the sequencer
   typedef struct packed {
      logic left_wr;
      logic left_rd;
      logic right_wr;
      logic right_rd;
   } tbl_ctrl_type;

endpackage

[rtl/lin_table_basis_index.sv]
`timescale 1ns / 1ps
// Top level of the two-level basis index: configuration registers, request
// intake and response register. Depends on ltbi_pkg, ltbi_engine, ltbi_tables.
//
// A lookup's pattern is split and each half multiplied by the depth reciprocal in
// the transfer cycle; the next cycle finishes the reduction to table addresses and
// reads both tables, and the cycle after that sums the read data through the
// shared adder, and the sum moves into the response register once that is free. A
// new request is taken the cycle after the result has moved to the response
// register, so no new lookup is taken while one is in flight; a stalled
// response holds the engine. A build writes one left-table entry per cycle
// through the shared adder for each pattern of the L = floor(n/2) left sites,
// does one read and add for the basis size, writes one right-table entry per
// cycle over the whole depth, and then hands the size over to the response
// register.
// Tables keep the site and ones counts of the last build; register writes
// afterwards take effect at the next build.
module lin_table_basis_index #(
   parameter int MAX_SITES        = ltbi_pkg::DEF_MAX_SITES,
   parameter int HALF_TABLE_DEPTH = ltbi_pkg::DEF_HALF_TABLE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ltbi_pkg::PATTERN_W-1:0]       req_tdata,   // [15:0] pattern
   input  logic                                 req_tuser,   // [0] cmd
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [ltbi_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [13:0] value, [15:14] zero
   output logic [ltbi_pkg::STATUS_W-1:0]        rsp_tuser,   // [1:0] status
   // configuration writes
   input  logic                                 csr_wr_en,
   input  logic [ltbi_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ltbi_pkg::CFG_W-1:0]           csr_wdata
);
   import ltbi_pkg::*;

   localparam int AW = $clog2(HALF_TABLE_DEPTH);

   logic [CFG_W-1:0]    site_count_ff, site_count_in;
   logic [CFG_W-1:0]    ones_count_ff, ones_count_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                res_valid, res_ready;
   logic [VALUE_W-1:0]  res_value;
   logic [STATUS_W-1:0] res_status;
   tbl_ctrl_type        tbl_ctrl;
   logic [AW-1:0]       left_addr, right_addr;
   logic [VALUE_W-1:0]  left_wdata, left_rdata;
   logic [RANK_W-1:0]   right_wdata, right_rdata;

   // configuration register writes
   always_comb begin
      site_count_in = site_count_ff;
      ones_count_in = ones_count_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SITE_COUNT: site_count_in = csr_wdata;
            CSR_ONES_COUNT: ones_count_in = csr_wdata;
         endcase
      end
   end

   // response register: load a finished result whenever the slot frees up
   assign res_ready = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (res_valid && res_ready) begin
         rsp_tvalid_in = 1'b1;
         rsp_value_in  = res_value;
         rsp_status_in = res_status;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         site_count_ff <= SITE_COUNT_RESET;
         ones_count_ff <= ONES_COUNT_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         site_count_ff <= site_count_in;
         ones_count_ff <= ones_count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_value_ff);
   assign rsp_tuser  = rsp_status_ff;

   ltbi_engine #(
      .MAX_SITES        (MAX_SITES),
      .HALF_TABLE_DEPTH (HALF_TABLE_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_pattern (req_tdata),
      .site_count  (site_count_ff),
      .ones_count  (ones_count_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_value   (res_value),
      .res_status  (res_status),
      .tbl_ctrl    (tbl_ctrl),
      .left_addr   (left_addr),
      .left_wdata  (left_wdata),
      .left_rdata  (left_rdata),
      .right_addr  (right_addr),
      .right_wdata (right_wdata),
      .right_rdata (right_rdata)
   );

   ltbi_tables #(
      .HALF_TABLE_DEPTH (HALF_TABLE_DEPTH)
   ) u_tables (
      .clock       (clock),
      .tbl_ctrl    (tbl_ctrl),
      .left_addr   (left_addr),
      .left_wdata  (left_wdata),
      .left_rdata  (left_rdata),
      .right_addr  (right_addr),
      .right_wdata (right_wdata),
      .right_rdata (right_rdata)
   );

endmodule

[rtl/ltbi_tables.sv]
`timescale 1ns / 1ps
// Left offset table and right rank table, one port each, registered reads.
// Depends on ltbi_pkg for field widths and the strobe struct.
module ltbi_tables #(
   parameter int HALF_TABLE_DEPTH = ltbi_pkg::DEF_HALF_TABLE_DEPTH
) (
   input  logic                                  clock,
   input  ltbi_pkg::tbl_ctrl_type                tbl_ctrl,
   input  logic [$clog2(HALF_TABLE_DEPTH)-1:0]   left_addr,
   input  logic [ltbi_pkg::VALUE_W-1:0]          left_wdata,
   output logic [ltbi_pkg::VALUE_W-1:0]          left_rdata,
   input  logic [$clog2(HALF_TABLE_DEPTH)-1:0]   right_addr,
   input  logic [ltbi_pkg::RANK_W-1:0]           right_wdata,
   output logic [ltbi_pkg::RANK_W-1:0]           right_rdata
);
   import ltbi_pkg::*;

   logic [VALUE_W-1:0] left_mem  [HALF_TABLE_DEPTH];
   logic [RANK_W-1:0]  right_mem [HALF_TABLE_DEPTH];
   logic [VALUE_W-1:0] left_rdata_ff;
   logic [RANK_W-1:0]  right_rdata_ff;

   // Left table: write or read at the shared address, hold read data otherwise
   always_ff @(posedge clock) begin
      if (tbl_ctrl.left_wr) begin
         left_mem[left_addr] <= left_wdata;
      end
      if (tbl_ctrl.left_rd) begin
         left_rdata_ff <= left_mem[left_addr];
      end
   end

   // Right table: same arrangement
   always_ff @(posedge clock) begin
      if (tbl_ctrl.right_wr) begin
         right_mem[right_addr] <= right_wdata;
      end
      if (tbl_ctrl.right_rd) begin
         right_rdata_ff <= right_mem[right_addr];
      end
   end

   assign left_rdata  = left_rdata_ff;
   assign right_rdata = right_rdata_ff;

endmodule

[rtl/ltbi_engine.sv]
`timescale 1ns / 1ps
// Sequencer and shared adder: walks the tables on a build, reads and sums them
// on a lookup. Depends on ltbi_pkg; drives the ports of ltbi_tables.
module ltbi_engine #(
   parameter int MAX_SITES        = ltbi_pkg::DEF_MAX_SITES,
   parameter int HALF_TABLE_DEPTH = ltbi_pkg::DEF_HALF_TABLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request side
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic [ltbi_pkg::PATTERN_W-1:0]        req_pattern,
   // configuration
   input  logic [ltbi_pkg::CFG_W-1:0]            site_count,
   input  logic [ltbi_pkg::CFG_W-1:0]            ones_count,
   // result side
   output logic                                  res_valid,
   input  logic                                  res_ready,
   output logic [ltbi_pkg::VALUE_W-1:0]          res_value,
   output logic [ltbi_pkg::STATUS_W-1:0]         res_status,
   // table ports
   output ltbi_pkg::tbl_ctrl_type                tbl_ctrl,
   output logic [$clog2(HALF_TABLE_DEPTH)-1:0]   left_addr,
   output logic [ltbi_pkg::VALUE_W-1:0]          left_wdata,
   input  logic [ltbi_pkg::VALUE_W-1:0]          left_rdata,
   output logic [$clog2(HALF_TABLE_DEPTH)-1:0]   right_addr,
   output logic [ltbi_pkg::RANK_W-1:0]           right_wdata,
   input  logic [ltbi_pkg::RANK_W-1:0]           right_rdata
);
   import ltbi_pkg::*;

   localparam int AW    = $clog2(HALF_TABLE_DEPTH);
   localparam int RMAX  = (MAX_SITES + 1) / 2;
   localparam int LMAX  = MAX_SITES / 2;
   localparam int LW    = LMAX;
   localparam int SW    = $clog2(MAX_SITES + 1);
   localparam int RIW   = $clog2(RMAX + 1);
   localparam int LIW   = $clog2(LMAX + 1);
   // reciprocal for the table-depth reduction of a pattern half
   localparam int SHIFT = PATTERN_W + AW;
   localparam logic [17:0] RECIP = 18'(((64'd1 << SHIFT) + 64'(HALF_TABLE_DEPTH) - 64'd1)
                                       / 64'(HALF_TABLE_DEPTH));
   localparam logic [16:0]   DEPTH_C   = 17'(HALF_TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(HALF_TABLE_DEPTH - 1);
   localparam logic [5:0]    MAX_C     = 6'(MAX_SITES);

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_LK_RED   = 3'd1;
   localparam logic [2:0] S_LK_SUM   = 3'd2;
   localparam logic [2:0] S_BL_LEFT  = 3'd3;
   localparam logic [2:0] S_BL_READ  = 3'd4;
   localparam logic [2:0] S_BL_TOTAL = 3'd5;
   localparam logic [2:0] S_BL_RIGHT = 3'd6;
   localparam logic [2:0] S_BL_DONE  = 3'd7;

   // binomial(n, k) by Pascal's rule, wrapped to the value width
   function automatic int binom_const(input int n, input int k);
      int row [0:32];
      for (int i = 0; i <= 32; i++) row[i] = 0;
      row[0] = 1;
      for (int i = 1; i <= n; i++) begin
         for (int j = i; j >= 1; j--) row[j] = (row[j] + row[j-1]) & 16'h3FFF;
      end
      return row[k];
   endfunction

   function automatic logic [4:0] pop16(input logic [15:0] v);
      logic [4:0] c;
      c = '0;
      for (int i = 0; i < 16; i++) c = c + 5'(v[i]);
      return c;
   endfunction

   logic [2:0]           state_ff, state_in;
   logic                 built_ff, built_in;
   logic [RANK_W-1:0]    cnt_ff [RMAX+1];
   logic [RANK_W-1:0]    cnt_in [RMAX+1];
   logic [LW-1:0]        l_ff, l_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic                 wrapped_ff, wrapped_in;
   logic [VALUE_W-1:0]   acc_ff, acc_in;
   logic [SW-1:0]        bld_sites_ff, bld_sites_in;
   logic [RIW-1:0]       bld_r_ff, bld_r_in;
   logic [LIW-1:0]       bld_l_ff, bld_l_in;
   logic [CFG_W-1:0]     bld_k_ff, bld_k_in;
   logic [PATTERN_W-1:0] rhalf_ff, rhalf_in, lhalf_ff, lhalf_in;
   logic [PATTERN_W-1:0] qr_ff, qr_in, ql_ff, ql_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic [VALUE_W-1:0]   binom_tab [RMAX+1][RMAX+1];
   logic [VALUE_W-1:0]   add_a, add_b, add_sum;
   logic [4:0]           p_sel, j_sel;
   logic                 term_ok;
   logic [VALUE_W-1:0]   term;
   logic [LW-1:0]        lmask;
   logic [AW-1:0]        rmask_aw;
   logic [PATTERN_W-1:0] site_mask, rmask16, masked;
   logic [33:0]          prod_r, prod_l;
   logic [32:0]          back_r, back_l;
   logic [PATTERN_W-1:0] rem_r, rem_l;
   logic [AW-1:0]        raddr_calc, laddr_calc;
   logic [4:0]           rp;
   logic                 r_valid;
   logic [RIW-1:0]       cnt_idx;
   logic [5:0]           n6, r6;

   // constant binomial table, rows by right-half width
   for (genvar gn = 0; gn <= RMAX; gn++) begin : g_brow
      for (genvar gk = 0; gk <= RMAX; gk++) begin : g_bcol
         assign binom_tab[gn][gk] = VALUE_W'(binom_const(gn, gk));
      end
   end

   // bit masks from the latched site split
   always_comb begin
      for (int i = 0; i < PATTERN_W; i++) begin
         site_mask[i] = 6'(i) < 6'(bld_sites_ff);
         rmask16[i]   = 6'(i) < 6'(bld_r_ff);
      end
      for (int i = 0; i < LW; i++) lmask[i] = 6'(i) < 6'(bld_l_ff);
      for (int i = 0; i < AW; i++) rmask_aw[i] = 6'(i) < 6'(bld_r_ff);
   end

   // clamp the site count and split it for a new build
   always_comb begin
      n6 = 6'(site_count);
      if (n6 == 6'd0) begin
         n6 = 6'd1;
      end else if (n6 > MAX_C) begin
         n6 = MAX_C;
      end
      r6 = (n6 + 6'd1) >> 1;
   end

   // split and reduce the pattern halves of a lookup request
   assign masked = req_pattern & site_mask;
   assign prod_r = 34'(masked & rmask16) * 34'(RECIP);
   assign prod_l = 34'(masked >> bld_r_ff) * 34'(RECIP);
   assign back_r = 33'(qr_ff) * 33'(DEPTH_C);
   assign back_l = 33'(ql_ff) * 33'(DEPTH_C);
   assign rem_r  = rhalf_ff - 16'(back_r);
   assign rem_l  = lhalf_ff - 16'(back_l);
   assign raddr_calc = AW'(rem_r);
   assign laddr_calc = AW'(rem_l);

   // binomial term for the current popcount
   always_comb begin
      p_sel   = (state_ff == S_BL_TOTAL) ? 5'(bld_l_ff) : pop16(16'(l_ff));
      j_sel   = bld_k_ff - p_sel;
      term_ok = (p_sel <= bld_k_ff) && (j_sel <= 5'(bld_r_ff));
      term    = term_ok ? binom_tab[bld_r_ff][RIW'(j_sel)] : '0;
   end

   // right-half rank for the sweep
   assign rp      = pop16(16'(addr_ff));
   assign r_valid = ((addr_ff & ~rmask_aw) == '0) && (rp <= bld_k_ff)
                    && ((bld_k_ff - rp) <= 5'(bld_l_ff));
   assign cnt_idx = RIW'(rp);

   // the shared adder
   assign add_sum = add_a + add_b;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      built_in     = built_ff;
      cnt_in       = cnt_ff;
      l_in         = l_ff;
      addr_in      = addr_ff;
      wrapped_in   = wrapped_ff;
      acc_in       = acc_ff;
      bld_sites_in = bld_sites_ff;
      bld_r_in     = bld_r_ff;
      bld_l_in     = bld_l_ff;
      bld_k_in     = bld_k_ff;
      rhalf_in     = rhalf_ff;
      lhalf_in     = lhalf_ff;
      qr_in        = qr_ff;
      ql_in        = ql_ff;
      status_in    = status_ff;
      tbl_ctrl     = '0;
      left_addr    = addr_ff;
      right_addr   = addr_ff;
      left_wdata   = acc_ff;
      right_wdata  = r_valid ? cnt_ff[cnt_idx] : RANK_UNUSED;
      add_a        = acc_ff;
      add_b        = term;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      res_value    = acc_ff;
      res_status   = STATUS_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_BUILD) begin
                  bld_sites_in = SW'(n6);
                  bld_r_in     = RIW'(r6);
                  bld_l_in     = LIW'(n6 - r6);
                  bld_k_in     = ones_count;
                  built_in     = 1'b1;
                  for (int i = 0; i <= RMAX; i++) cnt_in[i] = '0;
                  l_in       = '0;
                  addr_in    = '0;
                  wrapped_in = 1'b0;
                  acc_in     = '0;
                  state_in   = S_BL_LEFT;
               end else begin
                  rhalf_in = masked & rmask16;
                  lhalf_in = masked >> bld_r_ff;
                  qr_in    = 16'(prod_r >> SHIFT);
                  ql_in    = 16'(prod_l >> SHIFT);
                  if (!built_ff) begin
                     status_in = STATUS_NOT_BUILT;
                  end else if (pop16(masked) != bld_k_ff) begin
                     status_in = STATUS_MISMATCH;
                  end else begin
                     status_in = STATUS_OK;
                  end
                  state_in = S_LK_RED;
               end
            end
         end
         S_LK_RED: begin
            left_addr         = laddr_calc;
            right_addr        = raddr_calc;
            tbl_ctrl.left_rd  = 1'b1;
            tbl_ctrl.right_rd = 1'b1;
            state_in          = S_LK_SUM;
         end
         S_LK_SUM: begin
            add_a      = left_rdata;
            add_b      = VALUE_W'(right_rdata);
            res_valid  = 1'b1;
            res_value  = (status_ff == STATUS_OK) ? add_sum : '0;
            res_status = status_ff;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         S_BL_LEFT: begin
            // store the prefix sum, then advance it by the binomial term
            tbl_ctrl.left_wr = !wrapped_ff;
            acc_in           = add_sum;
            if (l_ff == lmask) begin
               state_in = S_BL_READ;
            end else begin
               l_in = l_ff + LW'(1);
               if (addr_ff == LAST_ADDR) begin
                  addr_in    = '0;
                  wrapped_in = 1'b1;
               end else begin
                  addr_in = addr_ff + AW'(1);
               end
            end
         end
         S_BL_READ: begin
            tbl_ctrl.left_rd = 1'b1;
            state_in         = S_BL_TOTAL;
         end
         S_BL_TOTAL: begin
            add_a    = left_rdata;
            acc_in   = add_sum;
            addr_in  = '0;
            state_in = S_BL_RIGHT;
         end
         S_BL_RIGHT: begin
            tbl_ctrl.right_wr = 1'b1;
            if (r_valid) begin
               cnt_in[cnt_idx] = cnt_ff[cnt_idx] + RANK_W'(1);
            end
            if (addr_ff == LAST_ADDR) begin
               state_in = S_BL_DONE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_BL_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // control registers and the latched split of the last build
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         built_ff     <= 1'b0;
         for (int i = 0; i <= RMAX; i++) cnt_ff[i] <= '0;
         bld_sites_ff <= '0;
         bld_r_ff     <= '0;
         bld_l_ff     <= '0;
         bld_k_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         cnt_ff       <= cnt_in;
         bld_sites_ff <= bld_sites_in;
         bld_r_ff     <= bld_r_in;
         bld_l_ff     <= bld_l_in;
         bld_k_ff     <= bld_k_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      l_ff         <= l_in;
      addr_ff      <= addr_in;
      wrapped_ff   <= wrapped_in;
      acc_ff       <= acc_in;
      rhalf_ff     <= rhalf_in;
      lhalf_ff     <= lhalf_in;
      qr_ff        <= qr_in;
      ql_ff        <= ql_in;
      status_ff    <= status_in;
   end

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_status))
      else $error("result changed while stalled");

   // reduced lookup addresses fall inside the tables
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LK_RED |-> ({1'b0, laddr_calc} < (AW+1)'(HALF_TABLE_DEPTH))
                            && ({1'b0, raddr_calc} < (AW+1)'(HALF_TABLE_DEPTH)))
      else $error("lookup address beyond table depth");

   // a build answers only after the full right sweep
   assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_BL_DONE) |-> ($past(state_ff) == S_BL_RIGHT)
                                    && ($past(addr_ff) == LAST_ADDR))
      else $error("build finished before the right sweep");

   // lookups before any build report unbuilt tables
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LK_SUM && !built_ff |-> res_status == STATUS_NOT_BUILT
                                          && res_value == '0)
      else $error("lookup on unbuilt tables not flagged");

endmodule
